[src/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the Playfair digraph cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int LetterW = 5;
	localparam int Side    = 5;
	localparam int IdxW    = $clog2(Side);
	localparam int RowsW   = 2 * Side * LetterW;
	localparam int Row4W   = Side * LetterW;

	typedef logic [LetterW-1:0] letter_t;
	typedef logic [IdxW-1:0]    pos_t;
	typedef logic [Side-1:0][Side-1:0][LetterW-1:0] square_t;

	localparam letter_t LETTER_I = letter_t'(8);
	localparam letter_t LETTER_J = letter_t'(9);
	localparam letter_t LETTER_X = letter_t'(23);

	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_ROWS_0_1 = 2'd1;
	localparam logic [1:0] CFG_ROWS_2_3 = 2'd2;
	localparam logic [1:0] CFG_ROW_4    = 2'd3;

	typedef struct packed {
		letter_t a;
		letter_t b;
		logic    last;
	} pair_t;

endpackage

[src/pfc_pair_gen.sv]
// ----------------------------------------------------------------------------
// pfc_pair_gen
// Input stage: holds the pending letter, forms digraphs per item and queues
// up to two pairs for substitution.
// ----------------------------------------------------------------------------
module pfc_pair_gen import pfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  letter_t letter_in,
	input  logic    message_end,
	input  logic    decrypt_mode,
	input  logic    take,
	output logic    pair_valid,
	output pair_t   pair
);

	logic    pend_v_q;
	letter_t pend_q;
	pair_t   pairs_s1 [2];
	logic [1:0] cnt_s1;

	logic    accept;
	logic    move;
	logic    nxt_v;
	letter_t nxt_l;
	pair_t   g0;
	pair_t   g1;
	logic [1:0] gcnt;

	assign pair_valid = (cnt_s1 != 2'd0);
	assign pair       = pairs_s1[0];
	assign move       = pair_valid && take;
	assign in_stall   = (cnt_s1 == 2'd2) || ((cnt_s1 == 2'd1) && !take);
	assign accept     = in_valid && !in_stall;

	always_comb begin
		nxt_v = pend_v_q;
		nxt_l = pend_q;
		g0    = '0;
		g1    = '0;
		gcnt  = 2'd0;
		if (pend_v_q) begin
			if (!decrypt_mode && (pend_q == letter_in)) begin
				g0.a  = pend_q;
				g0.b  = LETTER_X;
				nxt_l = letter_in;
			end else begin
				g0.a  = pend_q;
				g0.b  = letter_in;
				nxt_v = 1'b0;
				nxt_l = '0;
			end
			gcnt = 2'd1;
		end else begin
			nxt_v = 1'b1;
			nxt_l = letter_in;
		end
		if (message_end && nxt_v) begin
			if (gcnt == 2'd0) begin
				g0.a = nxt_l;
				g0.b = LETTER_X;
			end else begin
				g1.a = nxt_l;
				g1.b = LETTER_X;
			end
			gcnt  = gcnt + 2'd1;
			nxt_v = 1'b0;
			nxt_l = '0;
		end
		g0.last = (gcnt == 2'd1);
		g1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_q   <= '0;
			cnt_s1   <= 2'd0;
		end else if (accept) begin
			pend_v_q <= nxt_v;
			pend_q   <= nxt_l;
			cnt_s1   <= gcnt;
		end else if (move) begin
			cnt_s1   <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pairs_s1[0] <= g0;
			pairs_s1[1] <= g1;
		end else if (move) begin
			pairs_s1[0] <= pairs_s1[1];
		end
	end

endmodule

[src/pfc_subst.sv]
// ----------------------------------------------------------------------------
// pfc_subst
// Digraph substitution through the 5x5 key square (row, column, rectangle).
// ----------------------------------------------------------------------------
module pfc_subst import pfc_pkg::*; (
	input  square_t sq,
	input  logic    decrypt_mode,
	input  letter_t a,
	input  letter_t b,
	output letter_t x,
	output letter_t y
);

	pos_t r1, c1, r2, c2;
	pos_t r1n, c1n, r2n, c2n;

	// first match in row-major order wins; no match gives row 0, column 0
	always_comb begin
		letter_t la, lb;
		la = (a == LETTER_J) ? LETTER_I : a;
		lb = (b == LETTER_J) ? LETTER_I : b;
		r1 = '0; c1 = '0; r2 = '0; c2 = '0;
		for (int r = Side - 1; r >= 0; r--) begin
			for (int c = Side - 1; c >= 0; c--) begin
				if (sq[r][c] == la) begin
					r1 = pos_t'(r);
					c1 = pos_t'(c);
				end
				if (sq[r][c] == lb) begin
					r2 = pos_t'(r);
					c2 = pos_t'(c);
				end
			end
		end
	end

	function automatic pos_t step(input pos_t p, input logic back);
		pos_t res;
		if (back)
			res = (p == '0) ? pos_t'(Side - 1) : p - pos_t'(1);
		else
			res = (p == pos_t'(Side - 1)) ? '0 : p + pos_t'(1);
		return res;
	endfunction

	always_comb begin
		if (r1 == r2) begin
			r1n = r1;
			r2n = r2;
			c1n = step(c1, decrypt_mode);
			c2n = step(c2, decrypt_mode);
		end else if (c1 == c2) begin
			r1n = step(r1, decrypt_mode);
			r2n = step(r2, decrypt_mode);
			c1n = c1;
			c2n = c2;
		end else begin
			r1n = r1;
			r2n = r2;
			c1n = c2;
			c2n = c1;
		end
	end

	assign x = sq[r1n][c1n];
	assign y = sq[r2n][c2n];

endmodule

[src/playfair_digraph_cipher_core.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// Playfair cipher over a stream of letters with a software-loaded key square.
// ----------------------------------------------------------------------------
// One letter enters per item; results leave one letter per cycle while
// out_stall is low. An item gives 0, 2 or 4 results (4 when a doubled letter
// is split in encrypt mode and message_end pads the held letter). Each digraph
// occupies the output register until both its letters have left, first then
// second: a stream of distinct letters runs at one item per cycle (two items
// per pair) while out_stall is low, and an item that releases one or two pairs
// by itself (doubled letter, one-letter message) waits on the output register.
// The first letter of a pair is offered once the pair moves from the queue
// into the output register. A two-entry pair queue sits between the input and
// output stages, so input items are taken while a result waits on out_stall
// until a pair is queued behind it. Load the square (index 1..3) and mode
// (index 0) while the core is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core import pfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  letter_t          letter_in,
	input  logic             message_end,
	output logic             out_valid,
	input  logic             out_stall,
	output letter_t          letter_out,
	output logic             run_last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [RowsW-1:0] cfg_data
);

	logic             mode_q;
	logic [RowsW-1:0] rows01_q;
	logic [RowsW-1:0] rows23_q;
	logic [Row4W-1:0] row4_q;
	square_t          sq;

	logic    take;
	logic    pair_valid;
	pair_t   pair;
	letter_t sub_x, sub_y;

	logic    vld_s2;
	logic    phase_s2;
	letter_t x_s2, y_s2;
	logic    last_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			rows01_q <= '0;
			rows23_q <= '0;
			row4_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:     mode_q   <= cfg_data[0];
				CFG_ROWS_0_1: rows01_q <= cfg_data;
				CFG_ROWS_2_3: rows23_q <= cfg_data;
				CFG_ROW_4:    row4_q   <= cfg_data[Row4W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < Side; c++) begin
			sq[0][c] = rows01_q[c*LetterW +: LetterW];
			sq[1][c] = rows01_q[(Side+c)*LetterW +: LetterW];
			sq[2][c] = rows23_q[c*LetterW +: LetterW];
			sq[3][c] = rows23_q[(Side+c)*LetterW +: LetterW];
			sq[4][c] = row4_q[c*LetterW +: LetterW];
		end
	end

	pfc_pair_gen u_pair_gen (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.letter_in    (letter_in),
		.message_end  (message_end),
		.decrypt_mode (mode_q),
		.take         (take),
		.pair_valid   (pair_valid),
		.pair         (pair)
	);

	pfc_subst u_subst (
		.sq           (sq),
		.decrypt_mode (mode_q),
		.a            (pair.a),
		.b            (pair.b),
		.x            (sub_x),
		.y            (sub_y)
	);

	// output register frees after the second letter of its pair leaves
	assign take = !vld_s2 || (phase_s2 && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			phase_s2 <= 1'b0;
		end else if (take) begin
			vld_s2   <= pair_valid;
			phase_s2 <= 1'b0;
		end else if (vld_s2 && !out_stall) begin
			phase_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pair_valid) begin
			x_s2    <= sub_x;
			y_s2    <= sub_y;
			last_s2 <= pair.last;
		end
	end

	assign out_valid  = vld_s2;
	assign letter_out = phase_s2 ? y_s2 : x_s2;
	assign run_last   = phase_s2 & last_s2;

endmodule
